>>> hw/rtl/sfb_pkg.sv
// Shared types and constants of the front/back strip hit matcher.
package sfb_pkg;

  localparam int VALUE_WIDTH     = 24;
  localparam int DET_W           = 4;
  localparam int STRIP_W         = 8;
  localparam int KIND_W          = 3;
  localparam int WINDOW_W        = 23;
  localparam int MAX_ENTRIES_DEF = 64;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(75);

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_FRONT_TIME  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BACK_ENERGY = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BACK_TIME   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY       = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NEW_EVENT   = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0]             kind;
    logic [DET_W-1:0]              detector;
    logic [STRIP_W-1:0]            strip;
    logic signed [VALUE_WIDTH-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [DET_W-1:0]              front_detector;
    logic [STRIP_W-1:0]            front_strip;
    logic signed [VALUE_WIDTH-1:0] front_energy;
    logic                          front_time_found;
    logic signed [VALUE_WIDTH-1:0] front_time;
    logic                          back_found;
    logic [STRIP_W-1:0]            back_strip;
    logic signed [VALUE_WIDTH-1:0] back_energy;
    logic                          back_time_found;
    logic signed [VALUE_WIDTH-1:0] back_time;
  } out_item_t;

  typedef struct packed {
    logic [DET_W-1:0]              det;
    logic [STRIP_W-1:0]            strip;
    logic signed [VALUE_WIDTH-1:0] value;
  } entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic wr_ft;
    logic wr_be;
    logic wr_bt;
    logic clear;
    logic capture;
    logic start_b;
    logic run;
    logic phase_b;
    logic push;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic a_done;
    logic b_done;
    logic out_full;
  } dp_status_t;

endpackage

>>> hw/rtl/sfb_table.sv
// Event table: append-only entry memory with fill count and registered read port.
module sfb_table #(
  parameter int  DEPTH = sfb_pkg::MAX_ENTRIES_DEF,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             clear,
  input  logic             wr_en,
  input  sfb_pkg::entry_t  wr_entry,
  input  logic [IDX_W-1:0] rd_addr,
  output sfb_pkg::entry_t  rd_data,
  output logic [CNT_W-1:0] count
);
  import sfb_pkg::*;

  entry_t mem [DEPTH];
  logic   full;

  assign full = (count == CNT_W'(DEPTH));

  // Track fill level; drop loads once full
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (clear) begin
      count <= '0;
    end else if (wr_en && !full) begin
      count <= count + 1'b1;
    end
  end

  // Append at the fill level, read one entry a cycle
  always_ff @(posedge clk) begin
    if (wr_en && !full && !clear) begin
      mem[count[IDX_W-1:0]] <= wr_entry;
    end
    rd_data <= mem[rd_addr];
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("table fill count beyond depth");

endmodule

>>> hw/rtl/sfb_datapath.sv
// Datapath: three event tables, query register, scan compare logic and result register.
module sfb_datapath #(
  parameter int  MAX_ENTRIES = sfb_pkg::MAX_ENTRIES_DEF,
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  sfb_pkg::ctrl_cmd_t             cmd,
  input  sfb_pkg::in_item_t              in_data,
  input  logic                           cfg_we,
  input  logic [sfb_pkg::WINDOW_W-1:0]   cfg_wdata,
  output sfb_pkg::dp_status_t            status,
  output logic                           out_valid,
  input  logic                           out_ready,
  output sfb_pkg::out_item_t             out_data
);
  import sfb_pkg::*;

  localparam int VW = VALUE_WIDTH;

  entry_t            wr_entry;
  entry_t            ft_rd, be_rd, bt_rd;
  logic [CNT_W-1:0]  ft_count, be_count, bt_count;

  logic [WINDOW_W-1:0]    window;
  logic [DET_W-1:0]       q_det;
  logic [STRIP_W-1:0]     q_strip;
  logic [VW-1:0]          q_val;

  logic [CNT_W-1:0]  idx, pidx;
  logic              pvld;

  logic              ft_done, ft_found;
  logic [VW-1:0]     ft_time;
  logic              be_done, be_found;
  logic [STRIP_W-1:0] be_strip;
  logic [VW-1:0]     be_energy;
  logic              b_done, bt_found;
  logic [VW-1:0]     bt_time;

  logic [VW:0]       diff, mag;
  logic              ft_hit, be_hit, bt_hit;
  out_item_t         result;

  assign wr_entry = '{det: in_data.detector, strip: in_data.strip, value: in_data.value};

  sfb_table #(.DEPTH(MAX_ENTRIES)) u_ft (
    .clk(clk), .rst(rst), .clear(cmd.clear), .wr_en(cmd.wr_ft), .wr_entry(wr_entry),
    .rd_addr(idx[IDX_W-1:0]), .rd_data(ft_rd), .count(ft_count)
  );

  sfb_table #(.DEPTH(MAX_ENTRIES)) u_be (
    .clk(clk), .rst(rst), .clear(cmd.clear), .wr_en(cmd.wr_be), .wr_entry(wr_entry),
    .rd_addr(idx[IDX_W-1:0]), .rd_data(be_rd), .count(be_count)
  );

  sfb_table #(.DEPTH(MAX_ENTRIES)) u_bt (
    .clk(clk), .rst(rst), .clear(cmd.clear), .wr_en(cmd.wr_bt), .wr_entry(wr_entry),
    .rd_addr(idx[IDX_W-1:0]), .rd_data(bt_rd), .count(bt_count)
  );

  // Hold the energy window
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WINDOW_RESET;
    end else if (cfg_we) begin
      window <= cfg_wdata;
    end
  end

  // Compare the entry read in the previous cycle
  always_comb begin
    diff   = {q_val[VW-1], q_val} - {be_rd.value[VW-1], be_rd.value};
    mag    = diff[VW] ? (~diff + 1'b1) : diff;
    ft_hit = (ft_rd.det == q_det) && (ft_rd.strip == q_strip);
    be_hit = (be_rd.det == q_det) && (mag < (VW + 1)'(window));
    bt_hit = (bt_rd.det == q_det) && (bt_rd.strip == be_strip);
  end

  // Scan the tables: front time and back energy together, then back time
  always_ff @(posedge clk) begin
    if (rst) begin
      pvld     <= 1'b0;
      ft_done  <= 1'b0;
      ft_found <= 1'b0;
      be_done  <= 1'b0;
      be_found <= 1'b0;
      b_done   <= 1'b0;
      bt_found <= 1'b0;
      idx      <= '0;
    end else if (cmd.capture) begin
      q_det    <= in_data.detector;
      q_strip  <= in_data.strip;
      q_val    <= in_data.value;
      idx      <= '0;
      pvld     <= 1'b0;
      ft_done  <= 1'b0;
      ft_found <= 1'b0;
      be_done  <= 1'b0;
      be_found <= 1'b0;
      b_done   <= 1'b0;
      bt_found <= 1'b0;
    end else if (cmd.start_b) begin
      idx    <= '0;
      pvld   <= 1'b0;
      b_done <= !be_found;
    end else if (cmd.run) begin
      pvld <= 1'b1;
      pidx <= idx;
      if (idx != CNT_W'(MAX_ENTRIES)) begin
        idx <= idx + 1'b1;
      end
      if (pvld && !cmd.phase_b) begin
        if (!ft_done) begin
          if (pidx >= ft_count) begin
            ft_done <= 1'b1;
          end else if (ft_hit) begin
            ft_done  <= 1'b1;
            ft_found <= 1'b1;
            ft_time  <= ft_rd.value;
          end
        end
        if (!be_done) begin
          if (pidx >= be_count) begin
            be_done <= 1'b1;
          end else if (be_hit) begin
            be_done   <= 1'b1;
            be_found  <= 1'b1;
            be_strip  <= be_rd.strip;
            be_energy <= be_rd.value;
          end
        end
      end else if (pvld && !b_done) begin
        if (pidx >= bt_count) begin
          b_done <= 1'b1;
        end else if (bt_hit) begin
          b_done   <= 1'b1;
          bt_found <= 1'b1;
          bt_time  <= bt_rd.value;
        end
      end
    end
  end

  // Assemble the result, zero where nothing matched
  always_comb begin
    result.front_detector   = q_det;
    result.front_strip      = q_strip;
    result.front_energy     = q_val;
    result.front_time_found = ft_found;
    result.front_time       = ft_found ? ft_time : '0;
    result.back_found       = be_found;
    result.back_strip       = be_found ? be_strip : '0;
    result.back_energy      = be_found ? be_energy : '0;
    result.back_time_found  = bt_found;
    result.back_time        = bt_found ? bt_time : '0;
  end

  // Hold the result until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_data <= result;
    end
  end

  assign status.a_done   = ft_done && be_done;
  assign status.b_done   = b_done;
  assign status.out_full = out_valid;

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !out_valid)
    else $error("result pushed over a pending result");

  a_skip_b: assert property (@(posedge clk) disable iff (rst)
    (cmd.start_b && !be_found) |=> (b_done && !bt_found))
    else $error("back time scan not skipped without back match");

  a_capture_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (!ft_done && !be_done && !b_done && !pvld))
    else $error("query capture left stale scan flags");

endmodule

>>> hw/rtl/sfb_ctrl.sv
// Controller: sequences loads, the two table scans and the result push.
module sfb_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [sfb_pkg::KIND_W-1:0]   kind,
  output logic                         in_ready,
  input  sfb_pkg::dp_status_t          status,
  output sfb_pkg::ctrl_cmd_t           cmd
);
  import sfb_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    SCAN_A,
    SCAN_B,
    EMIT
  } state_t;

  state_t state;
  logic   accept;

  assign in_ready = (state == IDLE);
  assign accept   = in_valid && in_ready;

  // Decode commands from state and the accepted item
  always_comb begin
    cmd = '0;
    case (state)
      IDLE: begin
        if (accept) begin
          case (kind)
            KIND_FRONT_TIME:  cmd.wr_ft   = 1'b1;
            KIND_BACK_ENERGY: cmd.wr_be   = 1'b1;
            KIND_BACK_TIME:   cmd.wr_bt   = 1'b1;
            KIND_NEW_EVENT:   cmd.clear   = 1'b1;
            KIND_QUERY:       cmd.capture = 1'b1;
            default: ;
          endcase
        end
      end
      SCAN_A: begin
        if (status.a_done) begin
          cmd.start_b = 1'b1;
        end else begin
          cmd.run = 1'b1;
        end
      end
      SCAN_B: begin
        if (!status.b_done) begin
          cmd.run     = 1'b1;
          cmd.phase_b = 1'b1;
        end
      end
      EMIT: begin
        cmd.push = !status.out_full;
      end
      default: ;
    endcase
  end

  // Advance the sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (accept && (kind == KIND_QUERY)) begin
            state <= SCAN_A;
          end
        end
        SCAN_A: begin
          if (status.a_done) begin
            state <= SCAN_B;
          end
        end
        SCAN_B: begin
          if (status.b_done) begin
            state <= EMIT;
          end
        end
        EMIT: begin
          if (!status.out_full) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/strip_front_back_hit_matcher.sv
// Front/back strip hit matcher, top level.
// Load items (front time, back energy, back time) and new-event items are taken only
// while the controller is idle; a load into a full table of MAX_ENTRIES entries is
// dropped. For a front energy query the front time and back energy tables are scanned
// together, one entry a cycle through their registered read ports, then the back time
// table is scanned for the matched back strip, if any, each scan running to the end of
// the table or its first match. The result sits in an output register, and loads are
// taken while it waits; a further query finishes its scans but delivers only once the
// previous result has been transferred.
module strip_front_back_hit_matcher #(
  parameter int MAX_ENTRIES = sfb_pkg::MAX_ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  sfb_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output sfb_pkg::out_item_t           out_data,
  input  logic                         cfg_we,
  input  logic [sfb_pkg::WINDOW_W-1:0] cfg_wdata
);
  import sfb_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  sfb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (in_data.kind),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  sfb_datapath #(.MAX_ENTRIES(MAX_ENTRIES)) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> dv/tb_strip_front_back_hit_matcher.sv
// Self-checking testbench for the front/back strip hit matcher.
module tb_strip_front_back_hit_matcher;
  timeunit 1ns;
  timeprecision 1ps;

  import sfb_pkg::*;

  localparam int TABLE_DEPTH   = MAX_ENTRIES_DEF;
  localparam int SETTLE_CYCLES = 160;     // longer than a whole query scan
  localparam int HOLD_CYCLES   = 2000;
  localparam int PHASE_ITEMS   = 200;
  localparam int NUM_PHASES    = 7;
  localparam int CYCLE_LIMIT   = 1_500_000;

  localparam logic [KIND_W-1:0] KIND_SPARE_5 = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;
  localparam logic [KIND_W-1:0] NOISE_KINDS [4] =
    '{KIND_QUERY, KIND_SPARE_5, KIND_SPARE_6, KIND_SPARE_7};

  localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN    = 24'sh800000;
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX    = 24'sh7FFFFF;
  localparam logic [WINDOW_W-1:0]           WINDOW_MAX = '1;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                cfg_we    = 1'b0;
  logic [WINDOW_W-1:0] cfg_wdata = '0;

  strip_front_back_hit_matcher u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Mirror of the hit tables and the energy window
  entry_t              ft_tab [TABLE_DEPTH];
  entry_t              be_tab [TABLE_DEPTH];
  entry_t              bt_tab [TABLE_DEPTH];
  int                  ft_cnt = 0;
  int                  be_cnt = 0;
  int                  bt_cnt = 0;
  logic [WINDOW_W-1:0] window_now = WINDOW_RESET;
  out_item_t           hits_due [$];

  bit          quiet      = 1'b0;
  bit          hold_req   = 1'b0;
  int unsigned hold_done  = 0;
  int unsigned items_done = 0;
  int unsigned queries    = 0;
  int unsigned drops      = 0;
  int unsigned results    = 0;
  int unsigned mismatches = 0;
  int unsigned cycles     = 0;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  dir_row_t dir_rows [$];

  // Append one row to the directed table
  function automatic void add_row(input in_item_t it, input bit typed, input out_item_t want);
    dir_row_t r;
    r.item  = it;
    r.typed = typed;
    r.want  = want;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic in_item_t mk(input logic [KIND_W-1:0] k, input logic [DET_W-1:0] d,
                                  input logic [STRIP_W-1:0] s,
                                  input logic signed [VALUE_WIDTH-1:0] v);
    in_item_t it;
    it.kind     = k;
    it.detector = d;
    it.strip    = s;
    it.value    = v;
    return it;
  endfunction

  // Result of a query that finds nothing
  function automatic out_item_t echo_only(input in_item_t q);
    out_item_t r;
    r                = '0;
    r.front_detector = q.detector;
    r.front_strip    = q.strip;
    r.front_energy   = q.value;
    return r;
  endfunction

  // Append a load to its table, or drop it when the table is full
  function automatic void load_entry(input in_item_t it);
    entry_t e;
    e.det   = it.detector;
    e.strip = it.strip;
    e.value = it.value;
    case (it.kind)
      KIND_FRONT_TIME: begin
        if (ft_cnt < TABLE_DEPTH) begin
          ft_tab[ft_cnt] = e;
          ft_cnt++;
        end else drops++;
      end
      KIND_BACK_ENERGY: begin
        if (be_cnt < TABLE_DEPTH) begin
          be_tab[be_cnt] = e;
          be_cnt++;
        end else drops++;
      end
      KIND_BACK_TIME: begin
        if (bt_cnt < TABLE_DEPTH) begin
          bt_tab[bt_cnt] = e;
          bt_cnt++;
        end else drops++;
      end
      KIND_NEW_EVENT: begin
        ft_cnt = 0;
        be_cnt = 0;
        bt_cnt = 0;
      end
      default: ;
    endcase
  endfunction

  // Front time, back energy in window, then that back strip's time
  function automatic out_item_t match_query(input in_item_t q);
    out_item_t r;
    longint    diff;
    int        i;
    r = echo_only(q);
    for (i = 0; i < ft_cnt; i++) begin
      if (ft_tab[i].det == q.detector && ft_tab[i].strip == q.strip) begin
        r.front_time_found = 1'b1;
        r.front_time       = ft_tab[i].value;
        break;
      end
    end
    for (i = 0; i < be_cnt; i++) begin
      if (be_tab[i].det == q.detector) begin
        diff = longint'($signed(q.value)) - longint'($signed(be_tab[i].value));
        if (diff < 0) diff = -diff;
        if (diff < longint'(window_now)) begin
          r.back_found  = 1'b1;
          r.back_strip  = be_tab[i].strip;
          r.back_energy = be_tab[i].value;
          break;
        end
      end
    end
    if (r.back_found) begin
      for (i = 0; i < bt_cnt; i++) begin
        if (bt_tab[i].det == q.detector && bt_tab[i].strip == r.back_strip) begin
          r.back_time_found = 1'b1;
          r.back_time       = bt_tab[i].value;
          break;
        end
      end
    end
    return r;
  endfunction

  function automatic int unsigned idle_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    return $urandom_range(1, 4);
  endfunction

  function automatic int unsigned sender_gap();
    if (quiet || $urandom_range(0, 9) < 6) return 0;
    return idle_len();
  endfunction

  // Offer one item, hold it until the transfer, then predict its effect
  task automatic offer_item(input in_item_t it, input bit typed, input out_item_t want);
    int unsigned gap;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    if (it.kind == KIND_QUERY) begin
      hits_due.insert(hits_due.size(), typed ? want : match_query(it));
      queries++;
    end else begin
      load_entry(it);
    end
    if (it.kind <= KIND_NEW_EVENT) items_done++;
    gap = sender_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain, let any load finish, then write the window
  task automatic reconfigure(input logic [WINDOW_W-1:0] w);
    in_valid <= 1'b0;
    while (hits_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we     <= 1'b0;
    window_now = w;
  endtask

  function automatic in_item_t fresh_item(input logic [KIND_W-1:0] k,
                                          input logic [DET_W-1:0] d0, d1,
                                          input int unsigned strip_base, span,
                                          input int e_base);
    in_item_t it;
    it.kind     = k;
    it.detector = $urandom_range(0, 1) ? d0 : d1;
    it.strip    = STRIP_W'(strip_base + $urandom_range(0, 3));
    if ($urandom_range(0, 9) != 0 && (k == KIND_BACK_ENERGY || k == KIND_QUERY))
      it.value = VALUE_WIDTH'(e_base + int'($urandom_range(0, 2 * span + 2)) - int'(span) - 1);
    else
      it.value = VALUE_WIDTH'($urandom());
    return it;
  endfunction

  // One event: usually a new-event item, an optional flood of one table, then mixed traffic
  task automatic run_event();
    logic [DET_W-1:0]  d0, d1;
    logic [KIND_W-1:0] k;
    int unsigned       strip_base, span, pick, n_items, n_flood;
    int                e_base;
    in_item_t          it;
    d0         = DET_W'($urandom_range(0, 15));
    d1         = DET_W'($urandom_range(0, 15));
    strip_base = $urandom_range(0, 255);
    e_base     = int'($urandom_range(0, 24'hFFFFFF)) - 8388608;
    span       = (window_now > 2000) ? 2000 : int'(window_now);
    // now and then skip the new event so the tables carry over
    if ($urandom_range(0, 19) != 0)
      offer_item(mk(KIND_NEW_EVENT, DET_W'($urandom()), STRIP_W'($urandom()),
                    VALUE_WIDTH'($urandom())), 1'b0, '0);
    if ($urandom_range(0, 11) == 0) begin
      k       = KIND_W'($urandom_range(0, 2));
      n_flood = $urandom_range(62, 75);
      repeat (n_flood) offer_item(fresh_item(k, d0, d1, strip_base, span, e_base), 1'b0, '0);
    end
    n_items = $urandom_range(2, 16);
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        it.kind     = NOISE_KINDS[$urandom_range(0, 3)];
        it.detector = DET_W'($urandom());
        it.strip    = STRIP_W'($urandom());
        it.value    = VALUE_WIDTH'($urandom());
      end else begin
        if (pick < 26)      k = KIND_FRONT_TIME;
        else if (pick < 50) k = KIND_BACK_ENERGY;
        else if (pick < 66) k = KIND_BACK_TIME;
        else                k = KIND_QUERY;
        it = fresh_item(k, d0, d1, strip_base, span, e_base);
      end
      offer_item(it, 1'b0, '0);
    end
  endtask

  // Result receiver: random stalls, runs of readiness, and one long hold-off
  initial begin : rx_drive
    int unsigned n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        hold_done++;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        n = idle_len();
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 24);
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on result %0d, %s: expected %0h, got %0h", results, what, want, got);
  endtask

  task automatic compare_result(input out_item_t want, input out_item_t got);
    if (want.front_detector !== got.front_detector)
      note_mismatch("front_detector", 32'(want.front_detector), 32'(got.front_detector));
    if (want.front_strip !== got.front_strip)
      note_mismatch("front_strip", 32'(want.front_strip), 32'(got.front_strip));
    if (want.front_energy !== got.front_energy)
      note_mismatch("front_energy", 32'(want.front_energy), 32'(got.front_energy));
    if (want.front_time_found !== got.front_time_found)
      note_mismatch("front_time_found", 32'(want.front_time_found), 32'(got.front_time_found));
    if (want.front_time !== got.front_time)
      note_mismatch("front_time", 32'(want.front_time), 32'(got.front_time));
    if (want.back_found !== got.back_found)
      note_mismatch("back_found", 32'(want.back_found), 32'(got.back_found));
    if (want.back_strip !== got.back_strip)
      note_mismatch("back_strip", 32'(want.back_strip), 32'(got.back_strip));
    if (want.back_energy !== got.back_energy)
      note_mismatch("back_energy", 32'(want.back_energy), 32'(got.back_energy));
    if (want.back_time_found !== got.back_time_found)
      note_mismatch("back_time_found", 32'(want.back_time_found), 32'(got.back_time_found));
    if (want.back_time !== got.back_time)
      note_mismatch("back_time", 32'(want.back_time), 32'(got.back_time));
  endtask

  // Check every result transfer against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results++;
      if (hits_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d: %0h", results, out_data);
      end else begin
        compare_result(hits_due.pop_front(), out_data);
      end
    end
  end

  // Guard against a hung handshake
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, hits_due.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    in_item_t            q;
    out_item_t           w;
    logic [WINDOW_W-1:0] plan [NUM_PHASES];
    int unsigned         target;

    // Directed table: extremes, first-match order, window edge, spare kinds, new event
    q = mk(KIND_QUERY, 4'd0, 8'd0, '0);
    add_row(q, 1'b1, echo_only(q));
    q = mk(KIND_QUERY, 4'd15, 8'd255, VAL_MIN);
    add_row(q, 1'b1, echo_only(q));
    add_row(mk(KIND_FRONT_TIME, 4'd15, 8'd255, VAL_MAX), 1'b0, '0);
    add_row(mk(KIND_FRONT_TIME, 4'd15, 8'd255, 24'sd5), 1'b0, '0);
    add_row(mk(KIND_BACK_ENERGY, 4'd14, 8'd9, VAL_MIN + 24'sd10), 1'b0, '0);
    add_row(mk(KIND_BACK_ENERGY, 4'd15, 8'd7, VAL_MIN), 1'b0, '0);
    add_row(mk(KIND_BACK_TIME, 4'd15, 8'd7, VAL_MAX), 1'b0, '0);
    add_row(mk(KIND_BACK_TIME, 4'd15, 8'd7, -24'sd1), 1'b0, '0);
    q = mk(KIND_QUERY, 4'd15, 8'd255, VAL_MIN + 24'sd74);
    w                  = echo_only(q);
    w.front_time_found = 1'b1;
    w.front_time       = VAL_MAX;
    w.back_found       = 1'b1;
    w.back_strip       = 8'd7;
    w.back_energy      = VAL_MIN;
    w.back_time_found  = 1'b1;
    w.back_time        = VAL_MAX;
    add_row(q, 1'b1, w);
    add_row(mk(KIND_QUERY, 4'd15, 8'd255, VAL_MIN + 24'sd75), 1'b0, '0);
    add_row(mk(KIND_QUERY, 4'd15, 8'd255, VAL_MAX), 1'b0, '0);
    add_row(mk(KIND_BACK_ENERGY, 4'd15, 8'd200, '0), 1'b0, '0);
    add_row(mk(KIND_QUERY, 4'd15, 8'd0, 24'sd70), 1'b0, '0);
    add_row(mk(KIND_SPARE_5, 4'd3, 8'd3, 24'sd3), 1'b0, '0);
    add_row(mk(KIND_SPARE_6, 4'd0, 8'd0, '0), 1'b0, '0);
    add_row(mk(KIND_SPARE_7, 4'd15, 8'd255, -24'sd1), 1'b0, '0);
    add_row(mk(KIND_QUERY, 4'd15, 8'd255, '0), 1'b0, '0);
    add_row(mk(KIND_NEW_EVENT, 4'd15, 8'd255, VAL_MAX), 1'b0, '0);
    q = mk(KIND_QUERY, 4'd15, 8'd255, VAL_MIN + 24'sd74);
    add_row(q, 1'b1, echo_only(q));
    add_row(mk(KIND_BACK_ENERGY, 4'd0, 8'd255, VAL_MAX), 1'b0, '0);
    add_row(mk(KIND_QUERY, 4'd0, 8'd0, VAL_MAX - 24'sd74), 1'b0, '0);
    add_row(mk(KIND_NEW_EVENT, 4'd0, 8'd0, '0), 1'b0, '0);

    // Windows per phase; the first phase keeps the reset value
    plan[0] = WINDOW_RESET;
    plan[1] = '0;
    plan[2] = WINDOW_MAX;
    plan[3] = WINDOW_W'(1);
    plan[4] = WINDOW_W'($urandom_range(20, 600));
    plan[5] = WINDOW_RESET;
    plan[6] = WINDOW_W'($urandom_range(0, 23'h7FFFFF));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) offer_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    target = items_done;
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) reconfigure(plan[p]);
      quiet = (p == 3);
      // block the receiver for a long stretch while items keep coming
      if (p == 2) hold_req = 1'b1;
      target += PHASE_ITEMS;
      while (items_done < target) run_event();
    end

    in_valid <= 1'b0;
    while (hits_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    mismatches += hits_due.size();

    $display("run covered %0d items, %0d queries and %0d checked results over %0d windows",
             items_done, queries, results, NUM_PHASES);
    $display("loads dropped at a full table: %0d, long receiver hold-offs: %0d",
             drops, hold_done);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
